// ----- rtl/ffa_pkg.sv -----
// shared types and constants for the first-fit extent allocator
// extent record, operation codes, status codes, controller/datapath command bundles
// no dependencies
package ffa_pkg;

	localparam int ADDR_BITS        = 10;
	localparam int LEN_BITS         = ADDR_BITS + 1;
	localparam int COUNT_FIELD_BITS = 7;
	localparam int CFG_INDEX_BITS   = 1;
	localparam int CFG_DATA_BITS    = LEN_BITS;

	localparam logic [LEN_BITS-1:0]  SPACE_LIMIT  = {1'b1, {ADDR_BITS{1'b0}}};
	localparam logic [ADDR_BITS-1:0] RESET_BASE   = ADDR_BITS'(64);
	localparam logic [LEN_BITS-1:0]  RESET_LENGTH = LEN_BITS'(960);

	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_BASE   = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_LENGTH = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_FIT     = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	typedef enum logic [1:0] {
		FN_PROBE  = 2'd0,
		FN_ALLOC  = 2'd1,
		FN_FREE   = 2'd2,
		FN_REINIT = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_INIT,
		WR_REINIT,
		WR_CARVE,
		WR_MERGE_BOTH,
		WR_MERGE_LO,
		WR_MERGE_HI,
		WR_INSERT
	} wr_sel_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  length;
	} extent_t;

	typedef struct packed {
		logic       load;
		logic       scan_init;
		logic       scan_step;
		logic       dn_init;
		logic       dn_step;
		logic       up_init;
		logic       up_step;
		wr_sel_t    wr_sel;
		logic       res_load;
		logic [1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		func_t func;
		logic  size_zero;
		logic  scan_done;
		logic  hit;
		logic  exact;
		logic  join_lo;
		logic  join_hi;
		logic  full;
		logic  dn_done;
		logic  up_done;
		logic  out_free;
	} dp_stat_t;

	// trims a length so the extent ends at or below the top of the address space
	function automatic logic [LEN_BITS-1:0] clip_len(input logic [ADDR_BITS-1:0] start,
		input logic [LEN_BITS-1:0] len);
		logic [LEN_BITS-1:0] room;
		room = SPACE_LIMIT - {1'b0, start};
		return (len > room) ? room : len;
	endfunction

endpackage

// ----- rtl/first_fit_allocator_top.sv -----
// first-fit extent allocator with coalescing, top level; uses ffa_pkg, ffa_ctrl, ffa_datapath
// one operation at a time; a scan and any removal or insert shift handle one extent per cycle
// out_valid rises once the result is loaded, soonest for reinitialise or zero size and latest for a free
// inserted into a table one short of full; in_ready returns the cycle after the result is loaded.
// after reset the INIT state loads the default region into entry 0 before the first transfer;
// config applies at the next reinitialise
module first_fit_allocator_top
	import ffa_pkg::*;
#(
	parameter int MAX_EXTENTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [LEN_BITS-1:0]         request_size,
	input  logic [ADDR_BITS-1:0]        release_start,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [ADDR_BITS-1:0]        granted_start,
	output logic                        fits,
	output logic [COUNT_FIELD_BITS-1:0] extent_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffa_datapath #(
		.MAX_EXTENTS (MAX_EXTENTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.request_size  (request_size),
		.release_start (release_start),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.granted_start (granted_start),
		.fits          (fits),
		.extent_count  (extent_count)
	);

endmodule

// ----- rtl/ffa_ctrl.sv -----
// operation sequencer for the first-fit extent allocator
// drives scan, shift and table write commands into ffa_datapath; uses ffa_pkg
module ffa_ctrl
	import ffa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_START,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_INSERT,
		S_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] st_q, st_d;

	always_comb begin
		cmd      = '0;
		cmd.wr_sel = WR_NONE;
		in_ready = 1'b0;
		state_d  = state_q;
		st_d     = st_q;
		unique case (state_q)
			S_INIT: begin
				cmd.wr_sel = WR_INIT;
				state_d    = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				st_d = ST_OK;
				if (stat.func == FN_REINIT) begin
					cmd.wr_sel = WR_REINIT;
					state_d    = S_FINISH;
				end else if (stat.size_zero) begin
					// zero size never fits and a zero-size free is a no-op
					if (stat.func == FN_ALLOC)
						st_d = ST_NO_FIT;
					state_d = S_FINISH;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				unique case (stat.func)
					FN_PROBE: st_d = ST_OK;
					FN_ALLOC: begin
						if (!stat.hit) begin
							st_d = ST_NO_FIT;
						end else if (stat.exact) begin
							cmd.dn_init = 1'b1;
							state_d     = S_SHIFT_DN;
						end else begin
							cmd.wr_sel = WR_CARVE;
						end
					end
					FN_FREE: begin
						priority if (stat.join_lo && stat.join_hi) begin
							cmd.wr_sel  = WR_MERGE_BOTH;
							cmd.dn_init = 1'b1;
							state_d     = S_SHIFT_DN;
						end else if (stat.join_lo) begin
							cmd.wr_sel = WR_MERGE_LO;
						end else if (stat.join_hi) begin
							cmd.wr_sel = WR_MERGE_HI;
						end else if (stat.full) begin
							st_d = ST_TABLE_FULL;
						end else begin
							cmd.up_init = 1'b1;
							state_d     = S_SHIFT_UP;
						end
					end
					FN_REINIT: st_d = ST_OK;
				endcase
			end
			S_SHIFT_DN: begin
				cmd.dn_step = 1'b1;
				if (stat.dn_done)
					state_d = S_FINISH;
			end
			S_SHIFT_UP: begin
				cmd.up_step = 1'b1;
				if (stat.up_done)
					state_d = S_INSERT;
			end
			S_INSERT: begin
				cmd.wr_sel = WR_INSERT;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = st_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
		end
	end

endmodule

// ----- rtl/ffa_datapath.sv -----
// extent table, scan and shift pointers, config registers and result register
// executes ffa_ctrl commands; uses ffa_pkg
module ffa_datapath
	import ffa_pkg::*;
#(
	parameter int MAX_EXTENTS = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    stat,
	input  logic [1:0]                  func,
	input  logic [LEN_BITS-1:0]         request_size,
	input  logic [ADDR_BITS-1:0]        release_start,
	input  logic                        cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [CFG_DATA_BITS-1:0]    cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic [ADDR_BITS-1:0]        granted_start,
	output logic                        fits,
	output logic [COUNT_FIELD_BITS-1:0] extent_count
);

	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int XW = (CW > COUNT_FIELD_BITS) ? CW : COUNT_FIELD_BITS;

	extent_t mem [MAX_EXTENTS];
	extent_t rd_q;
	logic [IW-1:0] rd_addr;
	logic          we;
	logic [IW-1:0] wa;
	extent_t       wd;

	logic [CW-1:0] count_q, idx_q, pos_q;
	logic          vld_q, hit_q;
	extent_t       cur_q, prev_q;

	func_t                func_q;
	logic [LEN_BITS-1:0]  size_q, rel_len_q;
	logic [ADDR_BITS-1:0] rel_s_q;

	logic [ADDR_BITS-1:0] base_q;
	logic [LEN_BITS-1:0]  length_q;

	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [ADDR_BITS-1:0]        granted_q;
	logic                        fits_q;
	logic [COUNT_FIELD_BITS-1:0] count_out_q;

	logic [CW-1:0]        idx_m1, idx_m2, idx_p1, pos_m1, pos_p1;
	logic                 match, hit_now, end_now;
	logic [LEN_BITS-1:0]  reinit_len, init_len, carve_sum;
	logic [XW-1:0]        count_x;

	assign idx_m1 = idx_q - CW'(1);
	assign idx_m2 = idx_q - CW'(2);
	assign idx_p1 = idx_q + CW'(1);
	assign pos_m1 = pos_q - CW'(1);
	assign pos_p1 = pos_q + CW'(1);

	assign reinit_len = clip_len(base_q, length_q);
	assign init_len   = clip_len(RESET_BASE, RESET_LENGTH);
	assign carve_sum  = {1'b0, cur_q.start} + size_q;
	assign count_x    = XW'(count_q);

	// a free looks for the first start not below its own, a fit for the first long enough
	assign match   = (func_q == FN_FREE) ? ({1'b0, rd_q.start} >= {1'b0, rel_s_q})
		: (rd_q.length >= size_q);
	assign hit_now = vld_q && match;
	assign end_now = !hit_now && (idx_q == count_q);

	assign stat.func      = func_q;
	assign stat.size_zero = (size_q == '0);
	assign stat.scan_done = hit_now || end_now;
	assign stat.hit       = hit_q;
	assign stat.exact     = (cur_q.length == size_q);
	assign stat.join_hi   = hit_q && (({1'b0, rel_s_q} + rel_len_q) == {1'b0, cur_q.start});
	assign stat.join_lo   = (pos_q != '0)
		&& (({1'b0, prev_q.start} + prev_q.length) == {1'b0, rel_s_q});
	assign stat.full      = (count_q == CW'(MAX_EXTENTS));
	assign stat.dn_done   = (idx_q == count_q);
	assign stat.up_done   = (idx_q == pos_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	// read pointer: scans and downward shifts read at idx, upward shifts one below
	assign rd_addr = cmd.up_step ? idx_m1[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		if ((cmd.dn_step || cmd.up_step) && vld_q) begin
			we = 1'b1;
			wa = cmd.dn_step ? idx_m2[IW-1:0] : idx_p1[IW-1:0];
			wd = rd_q;
		end else begin
			unique case (cmd.wr_sel)
				WR_NONE: we = 1'b0;
				WR_INIT: begin
					we = 1'b1;
					wd = '{start: RESET_BASE, length: init_len};
				end
				WR_REINIT: begin
					we = 1'b1;
					wd = '{start: base_q, length: reinit_len};
				end
				WR_CARVE: begin
					we = 1'b1;
					wa = pos_q[IW-1:0];
					wd = '{start: carve_sum[ADDR_BITS-1:0], length: cur_q.length - size_q};
				end
				WR_MERGE_BOTH: begin
					we = 1'b1;
					wa = pos_m1[IW-1:0];
					wd = '{start: prev_q.start,
						length: prev_q.length + rel_len_q + cur_q.length};
				end
				WR_MERGE_LO: begin
					we = 1'b1;
					wa = pos_m1[IW-1:0];
					wd = '{start: prev_q.start, length: prev_q.length + rel_len_q};
				end
				WR_MERGE_HI: begin
					we = 1'b1;
					wa = pos_q[IW-1:0];
					wd = '{start: rel_s_q, length: rel_len_q + cur_q.length};
				end
				WR_INSERT: begin
					we = 1'b1;
					wa = pos_q[IW-1:0];
					wd = '{start: rel_s_q, length: rel_len_q};
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	// item, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func_t'(func);
			size_q    <= request_size;
			rel_s_q   <= release_start;
			rel_len_q <= clip_len(release_start, request_size);
		end
		if (cmd.scan_step) begin
			if (hit_now)
				cur_q <= rd_q;
			else if (vld_q)
				prev_q <= rd_q;
		end
		if (cmd.res_load) begin
			status_q    <= cmd.res_status;
			fits_q      <= hit_q && (func_q == FN_PROBE || func_q == FN_ALLOC);
			granted_q   <= (hit_q && func_q == FN_ALLOC) ? cur_q.start : '0;
			count_out_q <= count_x[COUNT_FIELD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CW'(1);
			idx_q       <= '0;
			pos_q       <= '0;
			vld_q       <= 1'b0;
			hit_q       <= 1'b0;
			base_q      <= RESET_BASE;
			length_q    <= RESET_LENGTH;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_REGION_BASE:   base_q   <= cfg_data[ADDR_BITS-1:0];
					REG_REGION_LENGTH: length_q <= cfg_data[LEN_BITS-1:0];
				endcase
			end

			if (cmd.load)
				hit_q <= 1'b0;

			if (cmd.scan_init) begin
				idx_q <= '0;
				vld_q <= 1'b0;
				hit_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (hit_now) begin
					hit_q <= 1'b1;
					pos_q <= idx_m1;
				end else if (end_now) begin
					pos_q <= idx_q;
				end else begin
					idx_q <= idx_p1;
					vld_q <= 1'b1;
				end
			end else if (cmd.dn_init) begin
				// close the gap at pos: move everything above it one slot down
				idx_q <= pos_p1;
				vld_q <= 1'b0;
			end else if (cmd.dn_step) begin
				if (stat.dn_done) begin
					count_q <= count_q - CW'(1);
				end else begin
					idx_q <= idx_p1;
					vld_q <= 1'b1;
				end
			end else if (cmd.up_init) begin
				// open a slot at pos, moving from the top entry downwards
				idx_q <= count_q;
				vld_q <= 1'b0;
			end else if (cmd.up_step) begin
				if (!stat.up_done) begin
					idx_q <= idx_m1;
					vld_q <= 1'b1;
				end
			end

			if (cmd.wr_sel == WR_REINIT)
				count_q <= (reinit_len != '0) ? CW'(1) : '0;
			else if (cmd.wr_sel == WR_INSERT)
				count_q <= count_q + CW'(1);

			if (cmd.res_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_start = granted_q;
	assign fits          = fits_q;
	assign extent_count  = count_out_q;

endmodule
